FILE: rtl/core/xcet_pkg.sv
`default_nettype none
package xcet_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [2:0] PH_NORMAL = 3'd0;
    localparam logic [2:0] PH_AMP    = 3'd1;
    localparam logic [2:0] PH_HASH   = 3'd2;
    localparam logic [2:0] PH_HEX    = 3'd3;
    localparam logic [2:0] PH_DEC    = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       insert;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry head;
    } t_q_status;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/xml_char_entity_terminator_core.sv
`default_nettype none
// Path: each input beat is written into the queue, then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; a byte closing a
//   reference with a non-';' byte takes two output beats, set by the single output register.
// Reset: synchronous active low; scan phase to normal text, queue and output emptied.
module xml_char_entity_terminator_core #(
    parameter int FIFO_DEPTH = xcet_pkg::FIFO_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);

    logic                q_full;
    logic                push;
    logic                pop;
    xcet_pkg::t_entry    entry;
    xcet_pkg::t_q_status q_status;

    xcet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_byte),
        .i_q_full (q_full),
        .o_ready  (o_in_ready),
        .o_push   (push),
        .o_entry  (entry)
    );

    xcet_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_status (q_status)
    );

    xcet_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (q_status),
        .o_pop    (pop),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_data   (o_out_byte),
        .o_last   (o_run_last)
    );

    a_insert_is_semi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_run_last) |-> (o_out_byte == xcet_pkg::CH_SEMI))
        else $error("inserted beat is not a semicolon");

    a_byte_follows_semi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> (o_out_valid && o_run_last))
        else $error("closing byte did not follow inserted semicolon");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

FILE: rtl/core/xcet_front.sv
`default_nettype none
module xcet_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_data,
    input  wire logic             i_q_full,
    output logic                  o_ready,
    output logic                  o_push,
    output xcet_pkg::t_entry      o_entry
);

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic       closing;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        n_phase = r_phase;
        closing = 1'b0;
        unique case (r_phase)
            xcet_pkg::PH_AMP: begin
                n_phase = (i_data == xcet_pkg::CH_HASH) ? xcet_pkg::PH_HASH
                                                        : xcet_pkg::PH_NORMAL;
            end
            xcet_pkg::PH_HASH: begin
                if (i_data == xcet_pkg::CH_X) begin
                    n_phase = xcet_pkg::PH_HEX;
                end else if (xcet_pkg::is_dec(i_data)) begin
                    n_phase = xcet_pkg::PH_DEC;
                end else begin
                    n_phase = xcet_pkg::PH_NORMAL;
                end
            end
            xcet_pkg::PH_HEX: begin
                closing = !xcet_pkg::is_hex(i_data);
            end
            xcet_pkg::PH_DEC: begin
                closing = !xcet_pkg::is_dec(i_data);
            end
            default: begin
                n_phase = (i_data == xcet_pkg::CH_AMP) ? xcet_pkg::PH_AMP
                                                       : xcet_pkg::PH_NORMAL;
            end
        endcase
        if (closing) begin
            n_phase = xcet_pkg::PH_NORMAL;
        end
    end

    assign o_entry.data   = i_data;
    assign o_entry.insert = closing && (i_data != xcet_pkg::CH_SEMI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcet_pkg::PH_NORMAL;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/xcet_fifo.sv
`default_nettype none
module xcet_fifo #(
    parameter int DEPTH = xcet_pkg::FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire xcet_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output xcet_pkg::t_q_status   o_status
);

    localparam int          AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    xcet_pkg::t_entry r_mem [2**AW];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;
    logic [AW:0]      count;
    logic             empty;

    assign count  = r_wr_ptr - r_rd_ptr;
    assign empty  = (r_wr_ptr == r_rd_ptr);
    assign o_full = (count == DEPTH_W);

    assign o_status.valid = !empty;
    assign o_status.head  = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/xcet_back.sv
`default_nettype none
module xcet_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire xcet_pkg::t_q_status i_status,
    output logic                     o_pop,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output logic [7:0]               o_data,
    output logic                     o_last
);

    logic       r_valid;
    logic       r_pend;
    logic [7:0] r_data;
    logic       r_last;
    logic       slot_free;

    assign slot_free = !r_valid || i_ready;
    // pop on the final beat of an entry
    assign o_pop = slot_free && i_status.valid && (r_pend || !i_status.head.insert);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (slot_free) begin
            r_valid <= i_status.valid;
            if (i_status.valid) begin
                r_pend <= !r_pend && i_status.head.insert;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && i_status.valid) begin
            if (!r_pend && i_status.head.insert) begin
                r_data <= xcet_pkg::CH_SEMI;
                r_last <= 1'b0;
            end else begin
                r_data <= i_status.head.data;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule
`default_nettype wire
